// ----- src/grid_heat_diffusion_step_defines.svh -----
// Assertion macros shared by the grid heat diffusion RTL.
// No dependencies; included by the modules that carry checks.
`ifndef GRID_HEAT_DIFFUSION_STEP_DEFINES_SVH
`define GRID_HEAT_DIFFUSION_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define GHD_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("ghd assertion failed");
`define GHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ghd assertion failed");
`else
`define GHD_ASSERT(lbl, clk, rstn, expr)
`define GHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/ghd_pkg.sv -----
// Types and constants for the grid heat diffusion block.
// No dependencies.
package ghd_pkg;
	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_STEP    = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic [1:0] REG_COEFF  = 2'd0;
	localparam logic [1:0] REG_BORDER = 2'd1;
	localparam logic [1:0] REG_SOURCE = 2'd2;
	localparam logic [1:0] REG_START  = 2'd3;

	localparam int COEF_W = 14;
	localparam int TEMP_W = 31;
	localparam int SRC_W  = 20;
	localparam int CFG_W  = 31;
	localparam int CELL_W = 32;
	localparam int D_W    = CELL_W + COEF_W - 16;

	localparam logic [COEF_W-1:0] COEF_RST   = 14'd13107;
	localparam logic [TEMP_W-1:0] BORDER_RST = 31'd1228800;
	localparam logic [SRC_W-1:0]  SOURCE_RST = 20'd40960;
	localparam logic [TEMP_W-1:0] START_RST  = 31'd1228800;

	// 273 K in Q20.12
	localparam logic [CELL_W:0] KELVIN_OFS = 33'd1118208;

	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] row;
		logic [6:0] col;
	} req_t;

	typedef struct packed {
		logic signed [31:0] celsius_value;
		logic               in_range;
	} rsp_t;

	typedef struct packed {
		logic load_in;    // latch request, clear result
		logic fill;       // write fill value at sweep address
		logic fill_reset; // fill with reset temperature
		logic rd_en;      // RAM read this cycle
		logic read_op;    // read address from latched row/col
		logic capture;    // read data valid, build result
		logic push;       // sweep element enters stencil pipe
		logic out_load;   // move result into output register
	} cmd_t;

	typedef struct packed {
		logic busy;       // stencil pipe holds work
	} sts_t;
endpackage

// ----- src/grid_heat_diffusion_step.sv -----
// Top level of the grid heat diffusion block: controller plus datapath.
// Depends on ghd_pkg, ghd_ctrl, ghd_dpath, ghd_ram.
//
// Explicit 2-D heat diffusion on a (GRID_SIZE+2)^2 grid of Q20.12 kelvin
// cells held in one RAM with a fixed-temperature border ring. A request
// carries an operation: restart fills every cell with start_temp; step
// streams the grid once through a two-row line buffer and a saturating
// stencil pipe, one cell per cycle, writing back in place, bound by the
// single RAM read port; read returns the cell minus 273 K, saturated,
// with in_range set for row/col 1..GRID_SIZE+1. Every request gets
// exactly one response transfer. One request is in flight at a time; a
// finished response waits in an output register while the next request
// is taken. After reset a clearing pass loads the reset start temperature;
// no request is taken during it, config writes are. Config writes belong
// in idle time only.
module grid_heat_diffusion_step #(
	parameter int GRID_SIZE = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  ghd_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output ghd_pkg::rsp_t              rsp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ghd_pkg::CFG_W-1:0]  cfg_data
);
	import ghd_pkg::*;

	localparam int SIDE  = GRID_SIZE + 2;
	localparam int CELLS = SIDE * SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int RC_W  = $clog2(SIDE + 1);

	cmd_t            cmd;
	sts_t            sts;
	logic [AW-1:0]   sweep_addr;
	logic [RC_W-1:0] sweep_row, sweep_col;

	// sequencing: counters, state, response valid
	ghd_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.operation  (req.operation),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.cmd        (cmd),
		.sts        (sts),
		.sweep_addr (sweep_addr),
		.sweep_row  (sweep_row),
		.sweep_col  (sweep_col)
	);

	// grid storage, stencil arithmetic, read conversion
	ghd_dpath #(.GRID_SIZE(GRID_SIZE)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sweep_addr (sweep_addr),
		.sweep_row  (sweep_row),
		.sweep_col  (sweep_col),
		.req        (req),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);
endmodule

// ----- src/ghd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ghd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4356
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- src/ghd_dpath.sv -----
// Datapath: config registers, grid RAM, stencil pipe, read conversion.
// Depends on ghd_pkg and ghd_ram.
module ghd_dpath #(
	parameter int GRID_SIZE = 64,
	parameter int SIDE      = GRID_SIZE + 2,
	parameter int CELLS     = SIDE * SIDE,
	parameter int AW        = $clog2(CELLS),
	parameter int RC_W      = $clog2(SIDE + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghd_pkg::cmd_t       cmd,
	output ghd_pkg::sts_t       sts,
	input  logic [AW-1:0]       sweep_addr,
	input  logic [RC_W-1:0]     sweep_row,
	input  logic [RC_W-1:0]     sweep_col,
	input  ghd_pkg::req_t       req,
	output ghd_pkg::rsp_t       rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [ghd_pkg::CFG_W-1:0] cfg_data
);
	import ghd_pkg::*;

	localparam int LINE   = 2 * SIDE + 1;
	localparam int SRC_LO = GRID_SIZE / 3;
	localparam int SRC_HI = GRID_SIZE * 2 / 3;
	localparam int RA_W   = AW + 8;

	function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
			input logic [CELL_W-1:0] b);
		logic [CELL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CELL_W] ? {CELL_W{1'b1}} : s[CELL_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] sat_sub(input logic [CELL_W-1:0] a,
			input logic [CELL_W-1:0] b);
		return (b >= a) ? '0 : a - b;
	endfunction

	function automatic logic sweep_row_in(input logic [RC_W-1:0] x);
		return (x != '0) && (32'(x) <= 32'(GRID_SIZE));
	endfunction

	// config
	logic [COEF_W-1:0] coef_q;
	logic [TEMP_W-1:0] border_q;
	logic [SRC_W-1:0]  src_q;
	logic [TEMP_W-1:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= COEF_RST;
			border_q <= BORDER_RST;
			src_q    <= SOURCE_RST;
			start_q  <= START_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEFF:  coef_q   <= cfg_data[COEF_W-1:0];
				REG_BORDER: border_q <= cfg_data[TEMP_W-1:0];
				REG_SOURCE: src_q    <= cfg_data[SRC_W-1:0];
				REG_START:  start_q  <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// latched request
	req_t          req_q;
	logic [AW-1:0] rd_addr_q;
	logic          in_rng;
	logic [RA_W-1:0] rd_addr_full;

	assign rd_addr_full = RA_W'(req.row) * RA_W'(SIDE) + RA_W'(req.col);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q     <= req;
			rd_addr_q <= rd_addr_full[AW-1:0];
		end
	end

	assign in_rng = (req_q.row != 7'd0) && (32'(req_q.row) <= 32'(GRID_SIZE + 1)) &&
		(req_q.col != 7'd0) && (32'(req_q.col) <= 32'(GRID_SIZE + 1));

	// grid RAM
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	logic              wr_s7;
	logic [CELL_W-1:0] new_s7;
	logic [AW-1:0]     wr_addr_q;

	always_comb begin
		if (cmd.fill) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr;
			ram_wdata = {1'b0, (cmd.fill_reset ? START_RST : start_q)};
		end else begin
			ram_we    = wr_s7;
			ram_waddr = wr_addr_q;
			ram_wdata = new_s7;
		end
	end

	assign ram_raddr = cmd.read_op ? rd_addr_q : sweep_addr;

	ghd_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// stencil pipe
	logic              push_s1, push_s2, cen_s3, vld_s4, vld_s5, vld_s6;
	logic [RC_W-1:0]   row_s1, col_s1, row_s2, col_s2;
	logic [RC_W-1:0]   row_s3, col_s3, row_s4, col_s4, row_s5, col_s5, row_s6, col_s6;
	logic [CELL_W-1:0] v_s2;
	logic [D_W-1:0]    d_s2;
	logic [CELL_W-1:0] line_v_q [LINE];
	logic [D_W-1:0]    line_d_q [LINE];
	logic [CELL_W-1:0] t_s4, t_s5, t_s6;
	logic [D_W-1:0]    ds_s4, dr_s4, dd_s4, dr_s5, dd_s5;
	logic              src_intr;
	logic [CELL_W+COEF_W-1:0] prod;
	logic              bord6, srcr6;

	assign src_intr = (sweep_row_in(row_s1)) && (sweep_row_in(col_s1));
	assign prod     = ram_rdata * (CELL_W+COEF_W)'(coef_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
			push_s2 <= 1'b0;
			cen_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			wr_s7   <= 1'b0;
		end else begin
			push_s1 <= cmd.push;
			push_s2 <= push_s1;
			cen_s3  <= push_s2 && (row_s2 != '0);
			vld_s4  <= cen_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			wr_s7   <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= sweep_row;
		col_s1 <= sweep_col;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		v_s2   <= ram_rdata;
		d_s2   <= src_intr ? prod[CELL_W+COEF_W-1:16] : '0;
		if (push_s2) begin
			line_v_q[0] <= v_s2;
			line_d_q[0] <= d_s2;
			for (int i = 1; i < LINE; i++) begin
				line_v_q[i] <= line_v_q[i-1];
				line_d_q[i] <= line_d_q[i-1];
			end
		end
		row_s3 <= row_s2 - RC_W'(1);
		col_s3 <= col_s2;
		// up and left contributions land first, in sweep order
		t_s4   <= sat_add(sat_add(line_v_q[SIDE], CELL_W'(line_d_q[2*SIDE])),
			CELL_W'(line_d_q[SIDE+1]));
		ds_s4  <= line_d_q[SIDE];
		dr_s4  <= line_d_q[SIDE-1];
		dd_s4  <= line_d_q[0];
		row_s4 <= row_s3;
		col_s4 <= col_s3;
		t_s5   <= sat_sub(t_s4, {ds_s4, 2'b00});
		dr_s5  <= dr_s4;
		dd_s5  <= dd_s4;
		row_s5 <= row_s4;
		col_s5 <= col_s4;
		t_s6   <= sat_add(sat_add(t_s5, CELL_W'(dr_s5)), CELL_W'(dd_s5));
		row_s6 <= row_s5;
		col_s6 <= col_s5;
		if (bord6) begin
			new_s7 <= {1'b0, border_q};
		end else if (srcr6) begin
			new_s7 <= sat_add(t_s6, CELL_W'(src_q));
		end else begin
			new_s7 <= t_s6;
		end
	end

	assign bord6 = (row_s6 == '0) || (row_s6 == RC_W'(SIDE - 1)) ||
		(col_s6 == '0) || (col_s6 == RC_W'(SIDE - 1));
	assign srcr6 = (32'(row_s6) > 32'(SRC_LO)) && (32'(row_s6) < 32'(SRC_HI)) &&
		(32'(col_s6) > 32'(SRC_LO)) && (32'(col_s6) < 32'(SRC_HI));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_addr_q <= '0;
		end else if (cmd.load_in) begin
			wr_addr_q <= '0;
		end else if (wr_s7 && !cmd.fill) begin
			wr_addr_q <= wr_addr_q + AW'(1);
		end
	end

	assign sts.busy = push_s1 | push_s2 | cen_s3 | vld_s4 | vld_s5 | vld_s6 | wr_s7;

	// result and output register
	rsp_t            res_q;
	logic [CELL_W:0] diff;

	assign diff = {1'b0, ram_rdata} - KELVIN_OFS;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_q <= '0;
		end else if (cmd.capture && in_rng) begin
			res_q.celsius_value <= (!diff[CELL_W] && diff[CELL_W-1]) ?
				32'sh7FFFFFFF : signed'(diff[CELL_W-1:0]);
			res_q.in_range      <= 1'b1;
		end
		if (cmd.out_load) begin
			rsp <= res_q;
		end
	end
endmodule

// ----- src/ghd_ctrl.sv -----
// Controller: sequences reset clear, restart fill, step sweep and reads.
// Depends on ghd_pkg and the assertion macro header.
`include "grid_heat_diffusion_step_defines.svh"
module ghd_ctrl #(
	parameter int GRID_SIZE = 64,
	parameter int SIDE      = GRID_SIZE + 2,
	parameter int CELLS     = SIDE * SIDE,
	parameter int AW        = $clog2(CELLS),
	parameter int RC_W      = $clog2(SIDE + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [1:0]      operation,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ghd_pkg::cmd_t   cmd,
	input  ghd_pkg::sts_t   sts,
	output logic [AW-1:0]   sweep_addr,
	output logic [RC_W-1:0] sweep_row,
	output logic [RC_W-1:0] sweep_col
);
	import ghd_pkg::*;

	localparam int CNT_W = $clog2(CELLS + SIDE);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_RD_A  = 3'd5;
	localparam logic [2:0] ST_RD_B  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [RC_W-1:0]  row_q, col_q;
	logic             last_fill, last_sweep, cnt_clr, out_ok;

	assign last_fill  = cnt_q == CNT_W'(CELLS - 1);
	assign last_sweep = cnt_q == CNT_W'(CELLS + SIDE - 1);
	assign req_ready  = state_q == ST_IDLE;
	assign out_ok     = !rsp_valid || rsp_ready;
	assign sweep_addr = cnt_q[AW-1:0];
	assign sweep_row  = row_q;
	assign sweep_col  = col_q;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cnt_clr        = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.fill       = 1'b1;
				cmd.fill_reset = 1'b1;
				if (last_fill) begin
					state_d = ST_IDLE;
					cnt_clr = 1'b1;
				end
			end
			ST_IDLE: begin
				cnt_clr = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					case (operation)
						OP_RESTART: state_d = ST_FILL;
						OP_STEP:    state_d = ST_STEP;
						OP_READ:    state_d = ST_RD_A;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (last_fill) begin
					state_d = ST_DONE;
				end
			end
			ST_STEP: begin
				cmd.push  = 1'b1;
				cmd.rd_en = cnt_q < CNT_W'(CELLS);
				if (last_sweep) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_RD_A: begin
				cmd.rd_en   = 1'b1;
				cmd.read_op = 1'b1;
				state_d     = ST_RD_B;
			end
			ST_RD_B: begin
				cmd.capture = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_ok) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cnt_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (col_q == RC_W'(SIDE - 1)) begin
					col_q <= '0;
					row_q <= row_q + RC_W'(1);
				end else begin
					col_q <= col_q + RC_W'(1);
				end
			end
			if (cmd.out_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	`GHD_ASSERT(a_ready_pipe_empty, clk, arst_n, !req_ready || !sts.busy)
	`GHD_ASSERT(a_fill_no_push, clk, arst_n, !(cmd.fill && cmd.push))
	`GHD_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, rsp_valid)
	`GHD_ASSERT_NEXT(a_step_drains, clk, arst_n, state_q == ST_STEP && last_sweep, sts.busy)
endmodule
